>>> rtl/aml_s5_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the S5 sleep-type scanner.
// No dependencies; used by every module of the block.
package aml_s5_pkg;

  localparam int WinDepth = 18;
  localparam int CntW     = $clog2(WinDepth + 1);

  // Name and package header bytes, first byte in entry 0.
  localparam logic [6:0][7:0] S5_HEAD = {8'h12, 8'h08, 8'h5F, 8'h35, 8'h53, 8'h5F, 8'h5C};

  localparam logic [7:0] OP_ZERO = 8'h00;
  localparam logic [7:0] OP_ONE  = 8'h01;
  localparam logic [7:0] OP_BYTE = 8'h0A;
  localparam logic [7:0] OP_WORD = 8'h0B;
  localparam logic [7:0] MIN_ELEMENTS = 8'h02;

  typedef logic [WinDepth-1:0][7:0] win_t;

  // One window position handed to the decoder, with the bytes left in the table.
  typedef struct packed {
    logic            valid;
    win_t            win;
    logic [CntW-1:0] avail;
  } cap_t;

endpackage

>>> rtl/aml_s5_win.sv
`timescale 1ns / 1ps
// Byte window and sequencing: fills the window, hands each start position
// to the decoder and flushes after the last byte. Depends on aml_s5_pkg.
module aml_s5_win
  import aml_s5_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output cap_t       cap_o,
  output logic       emit_req_o,
  input  logic       emit_go_i
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  win_t            win_q, win_d, win_wr;
  logic [CntW-1:0] fill_q, fill_d;
  logic            accept;

  assign in_ready_o = (state_q == ST_RUN);
  assign emit_req_o = (state_q == ST_EMIT);
  assign accept     = in_valid_i && in_ready_o;

  function automatic win_t shift_win(win_t w);
    win_t r;
    r = '0;
    for (int i = 0; i < WinDepth - 1; i++) begin
      r[i] = w[i+1];
    end
    return r;
  endfunction

  always_comb begin
    win_wr         = win_q;
    win_wr[fill_q] = in_byte_i;
    win_d          = win_q;
    fill_d         = fill_q;
    state_d        = state_q;
    cap_o          = '0;
    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          if (fill_q == CntW'(WinDepth - 1)) begin
            cap_o.valid = 1'b1;
            cap_o.win   = win_wr;
            cap_o.avail = CntW'(WinDepth);
            win_d       = shift_win(win_wr);
          end else begin
            win_d  = win_wr;
            fill_d = fill_q + CntW'(1);
          end
          if (in_last_i) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (fill_q != '0) begin
          cap_o.valid = 1'b1;
          cap_o.win   = win_q;
          cap_o.avail = fill_q;
          win_d       = shift_win(win_q);
          fill_d      = fill_q - CntW'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go_i) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

>>> rtl/aml_s5_match.sv
`timescale 1ns / 1ps
// Record decoder: registers one window position, tests it for the sleep
// package and holds the first hit. Depends on aml_s5_pkg.
module aml_s5_match
  import aml_s5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cap_t        cap_i,
  input  logic        clear_i,
  output logic        found_o,
  output logic [15:0] type_a_o,
  output logic [15:0] type_b_o
);

  typedef struct packed {
    logic            ok;
    logic [15:0]     val;
    logic [CntW-1:0] next;
  } dec_t;

  cap_t            ev_q;
  logic            seen_q;
  logic [15:0]     held_a_q, held_b_q;
  logic            hit;
  logic [CntW-1:0] cnt_pos;
  dec_t            dec_a, dec_b;

  function automatic dec_t take_int(win_t w, logic [CntW-1:0] p, logic [CntW-1:0] n);
    dec_t r;
    r = '0;
    if (p < n) begin
      unique case (w[p])
        OP_BYTE: begin
          r.ok   = (p + CntW'(1)) < n;
          r.val  = {8'h00, w[p + CntW'(1)]};
          r.next = p + CntW'(2);
        end
        OP_WORD: begin
          r.ok   = (p + CntW'(2)) < n;
          r.val  = {w[p + CntW'(2)], w[p + CntW'(1)]};
          r.next = p + CntW'(3);
        end
        OP_ZERO: begin
          r.ok   = 1'b1;
          r.val  = 16'd0;
          r.next = p + CntW'(1);
        end
        OP_ONE: begin
          r.ok   = 1'b1;
          r.val  = 16'd1;
          r.next = p + CntW'(1);
        end
        default: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

  always_comb begin
    cnt_pos = CntW'(8) + CntW'(ev_q.win[7][5:4]);
    dec_a   = take_int(ev_q.win, cnt_pos + CntW'(1), ev_q.avail);
    dec_b   = take_int(ev_q.win, dec_a.next, ev_q.avail);
    hit     = ev_q.valid && !seen_q
              && (ev_q.avail >= CntW'(8))
              && (ev_q.win[6:0] == S5_HEAD)
              && (cnt_pos < ev_q.avail)
              && (ev_q.win[cnt_pos] >= MIN_ELEMENTS)
              && dec_a.ok && dec_b.ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q     <= '0;
      seen_q   <= 1'b0;
      held_a_q <= '0;
      held_b_q <= '0;
    end else begin
      ev_q <= cap_i;
      if (clear_i) begin
        seen_q   <= 1'b0;
        held_a_q <= '0;
        held_b_q <= '0;
      end else if (hit) begin
        seen_q   <= 1'b1;
        held_a_q <= dec_a.val;
        held_b_q <= dec_b.val;
      end
    end
  end

  assign found_o  = seen_q;
  assign type_a_o = held_a_q;
  assign type_b_o = held_b_q;

  property p_seen_sticky;
    @(posedge clk_i) disable iff (!rst_ni)
      (seen_q && !clear_i) |=> (seen_q && $stable(held_a_q) && $stable(held_b_q));
  endproperty
  a_seen_sticky: assert property (p_seen_sticky)
    else $error("held sleep types changed after the first match");

  property p_no_eval_on_clear;
    @(posedge clk_i) disable iff (!rst_ni)
      clear_i |-> !ev_q.valid;
  endproperty
  a_no_eval_on_clear: assert property (p_no_eval_on_clear)
    else $error("window position still in decode when the result was taken");

endmodule

>>> rtl/aml_s5_sleep_type_scanner.sv
`timescale 1ns / 1ps
// Top level of the S5 sleep-type scanner: stream ports and result register.
// Depends on aml_s5_pkg, aml_s5_win and aml_s5_match.
//
// Table bytes are taken one per cycle. Each start position is decoded in the
// cycle after the byte that completes its 18-byte window arrives. After the
// request marked tlast, input is held off while the window is flushed, one
// position per cycle, for min(table length, 17) positions, after which the
// single result enters the output register and input resumes once the
// result register has room. The result carries the found flag in tuser and
// both sleep types in tdata, zero when nothing was found.
module aml_s5_sleep_type_scanner
  import aml_s5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] table_byte
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [15:0] sleep_type_a, [31:16] sleep_type_b
  output logic [0:0]  m_axis_tuser_o   // [0] found
);

  cap_t        cap;
  logic        emit_req, emit_go;
  logic        found;
  logic [15:0] type_a, type_b;
  logic        m_valid_q;
  logic        found_q;
  logic [31:0] data_q;

  aml_s5_win u_win (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .cap_o      (cap),
    .emit_req_o (emit_req),
    .emit_go_i  (emit_go)
  );

  aml_s5_match u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cap_i    (cap),
    .clear_i  (emit_go),
    .found_o  (found),
    .type_a_o (type_a),
    .type_b_o (type_b)
  );

  assign emit_go = emit_req && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit_go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      found_q <= found;
      data_q  <= found ? {type_b, type_a} : 32'd0;
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = data_q;
  assign m_axis_tuser_o[0] = found_q;

  property p_emit_loads;
    @(posedge clk_i) disable iff (!rst_ni)
      emit_go |=> m_valid_q;
  endproperty
  a_emit_loads: assert property (p_emit_loads)
    else $error("result taken but output register not loaded");

  property p_zero_when_absent;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_valid_q && !found_q) |-> (data_q == 32'd0);
  endproperty
  a_zero_when_absent: assert property (p_zero_when_absent)
    else $error("sleep types not zero in a result without a match");

  property p_no_input_while_emitting;
    @(posedge clk_i) disable iff (!rst_ni)
      emit_req |-> !s_axis_tready_o && !cap.valid;
  endproperty
  a_no_input_while_emitting: assert property (p_no_input_while_emitting)
    else $error("input or decode activity while the result is pending");

endmodule

>>> tb/tb_aml_s5_sleep_type_scanner.sv
`timescale 1ns / 1ps
// Testbench for aml_s5_sleep_type_scanner: streams directed and random tables and checks
// each result against a behavioural prediction of the S5 sleep package search.
// Depends on aml_s5_pkg and the scanner RTL; it needs no other file.
module tb_aml_s5_sleep_type_scanner;
  import aml_s5_pkg::*;

  typedef struct packed {
    logic        found;
    logic [15:0] type_b;
    logic [15:0] type_a;
  } sleep_types_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_LOW_COUNT,
    FLAW_BAD_FIRST_OP,
    FLAW_BAD_SECOND_OP,
    FLAW_BAD_HEAD
  } record_flaw_e;

  localparam int LongHold    = 400;
  localparam int DrainCycles = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;  // [7:0] table_byte
  logic        s_axis_tlast_i;  // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;  // [15:0] sleep_type_a, [31:16] sleep_type_b
  logic [0:0]  m_axis_tuser_o;  // [0] found

  logic [7:0]   table_bytes[$];
  logic [7:0]   draft_table[$];
  sleep_types_t awaited_sleep_types[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_orders;
  int bytes_accepted;
  int fail_count;

  aml_s5_sleep_type_scanner i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic bit decode_sleep_int(input int stop, inout int pos,
                                          output logic [15:0] val);
    val = '0;
    if (pos >= stop) return 1'b0;
    case (table_bytes[pos])
      OP_BYTE: begin
        if (pos + 1 >= stop) return 1'b0;
        val = {8'h00, table_bytes[pos + 1]};
        pos += 2;
        return 1'b1;
      end
      OP_WORD: begin
        if (pos + 2 >= stop) return 1'b0;
        val = {table_bytes[pos + 2], table_bytes[pos + 1]};
        pos += 3;
        return 1'b1;
      end
      OP_ZERO: begin
        val = 16'd0;
        pos += 1;
        return 1'b1;
      end
      OP_ONE: begin
        val = 16'd1;
        pos += 1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // A position only sees the bytes that lie both in its window and in the table.
  function automatic bit match_record_at(input int p, output logic [15:0] a,
                                         output logic [15:0] b);
    int stop;
    int pos;
    a = '0;
    b = '0;
    stop = (p + WinDepth < table_bytes.size()) ? p + WinDepth : table_bytes.size();
    if (stop - p < 7) return 1'b0;
    for (int k = 0; k < 7; k++) begin
      if (table_bytes[p + k] != S5_HEAD[k]) return 1'b0;
    end
    pos = p + 7;
    if (pos >= stop) return 1'b0;
    pos = pos + 1 + int'(table_bytes[pos][5:4]);
    if (pos >= stop) return 1'b0;
    if (table_bytes[pos] < MIN_ELEMENTS) return 1'b0;
    pos++;
    if (!decode_sleep_int(stop, pos, a)) return 1'b0;
    return decode_sleep_int(stop, pos, b);
  endfunction

  function automatic sleep_types_t predict_sleep_types();
    logic [15:0] a;
    logic [15:0] b;
    for (int p = 0; p < table_bytes.size(); p++) begin
      if (match_record_at(p, a, b)) return '{found: 1'b1, type_b: b, type_a: a};
    end
    return '0;
  endfunction

  task automatic send_table_byte(input logic [7:0] data, input logic last);
    logic ready_seen;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tlast_i  <= last;
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    bytes_accepted++;
    table_bytes.push_back(data);
    if (last) begin
      awaited_sleep_types.push_back(predict_sleep_types());
      table_bytes.delete();
    end
  endtask

  task automatic send_draft();
    for (int i = 0; i < draft_table.size(); i++) begin
      send_table_byte(draft_table[i], i == draft_table.size() - 1);
    end
  endtask

  function automatic void push_noise(input int n);
    repeat (n) draft_table.push_back(8'($urandom));
  endfunction

  function automatic void push_sleep_int(input bit bad_op);
    logic [7:0] op;
    if (bad_op) begin
      do op = 8'($urandom); while (op inside {OP_ZERO, OP_ONE, OP_BYTE, OP_WORD});
      draft_table.push_back(op);
      return;
    end
    case ($urandom_range(0, 3))
      0: draft_table.push_back(OP_ZERO);
      1: draft_table.push_back(OP_ONE);
      2: begin
        draft_table.push_back(OP_BYTE);
        push_noise(1);
      end
      default: begin
        draft_table.push_back(OP_WORD);
        push_noise(2);
      end
    endcase
  endfunction

  function automatic void push_record(input record_flaw_e flaw);
    logic [1:0] extra;
    int head_start;
    head_start = draft_table.size();
    for (int k = 0; k < 7; k++) draft_table.push_back(S5_HEAD[k]);
    if (flaw == FLAW_BAD_HEAD) begin
      draft_table[head_start + $urandom_range(0, 6)] ^= 8'($urandom_range(1, 255));
    end
    extra = 2'($urandom_range(0, 3));
    draft_table.push_back({2'($urandom), extra, 4'($urandom)});
    push_noise(int'(extra));
    if (flaw == FLAW_LOW_COUNT) draft_table.push_back(8'($urandom_range(0, 1)));
    else if ($urandom_range(0, 1)) draft_table.push_back(MIN_ELEMENTS);
    else draft_table.push_back(8'($urandom_range(2, 255)));
    push_sleep_int(flaw == FLAW_BAD_FIRST_OP);
    push_sleep_int(flaw == FLAW_BAD_SECOND_OP);
  endfunction

  // Mostly noise around one record, sometimes flawed, cut short or followed by a second one.
  function automatic void build_random_table();
    int shape;
    int rec_start;
    draft_table.delete();
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      push_noise($urandom_range(1, 40));
      return;
    end
    push_noise(($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10));
    rec_start = draft_table.size();
    if (shape < 65) begin
      push_record(FLAW_NONE);
    end else if (shape < 85) begin
      push_record(record_flaw_e'($urandom_range(1, 4)));
    end else begin
      push_record(FLAW_NONE);
      repeat ($urandom_range(1, draft_table.size() - rec_start - 1)) begin
        void'(draft_table.pop_back());
      end
      return;
    end
    if ($urandom_range(0, 1)) push_record(record_flaw_e'($urandom_range(0, 4)));
    push_noise($urandom_range(0, 6));
  endfunction

  task automatic test_short_tables();
    draft_table = '{8'hFF};
    send_draft();
    draft_table = '{8'h5C, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h08, 8'h12};
    send_draft();
  endtask

  task automatic test_integer_encodings();
    draft_table = '{8'h5C, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h08, 8'h12,
                    8'h00, 8'h02, 8'h00, 8'h01};
    send_draft();
    draft_table = '{8'h5C, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h08, 8'h12,
                    8'hF7, 8'hAA, 8'hBB, 8'hCC, 8'hFF, 8'h0B, 8'hFF, 8'hFF,
                    8'h0B, 8'h00, 8'h80};
    send_draft();
  endtask

  task automatic test_rejected_records();
    // A record with one element, then a valid one that must win.
    draft_table = '{8'h5C, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h08, 8'h12,
                    8'h00, 8'h01, 8'h00, 8'h01,
                    8'h5C, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h08, 8'h12,
                    8'h10, 8'h77, 8'h03, 8'h0A, 8'h5A, 8'h0A, 8'hA5};
    send_draft();
    draft_table = '{8'h5C, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h08, 8'h12,
                    8'h00, 8'h02, 8'h0C, 8'h01};
    send_draft();
    // The second integer runs past the end of the table.
    draft_table = '{8'h5C, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h08, 8'h12,
                    8'h00, 8'h02, 8'h0A, 8'h01, 8'h0B, 8'h34};
    send_draft();
  endtask

  task automatic test_random_tables(input int idle_pct, input int stall_pct, input int budget);
    int first;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = bytes_accepted;
    while (bytes_accepted - first < budget) begin
      build_random_table();
      send_draft();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_orders++;
    repeat (12) begin
      build_random_table();
      send_draft();
    end
  endtask

  initial begin
    int hold_left;
    int orders_seen;
    hold_left   = 0;
    orders_seen = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_orders != orders_seen) begin
        orders_seen = hold_orders;
        hold_left   = LongHold;
      end
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    sleep_types_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (awaited_sleep_types.size() == 0) begin
          $error("unexpected result: found %0d, data %h", m_axis_tuser_o[0], m_axis_tdata_o);
          fail_count++;
        end else begin
          want = awaited_sleep_types.pop_front();
          if (m_axis_tuser_o[0] !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, m_axis_tuser_o[0]);
            fail_count++;
          end
          if (m_axis_tdata_o[15:0] !== want.type_a) begin
            $error("sleep_type_a: expected %h, actual %h", want.type_a, m_axis_tdata_o[15:0]);
            fail_count++;
          end
          if (m_axis_tdata_o[31:16] !== want.type_b) begin
            $error("sleep_type_b: expected %h, actual %h", want.type_b, m_axis_tdata_o[31:16]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_orders    = 0;
    bytes_accepted = 0;
    fail_count     = 0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tlast_i  <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_tables();
    test_integer_encodings();
    test_rejected_records();
    test_random_tables(0, 0, 370);
    test_random_tables(79, 0, 370);
    test_random_tables(0, 79, 370);
    test_random_tables(31, 31, 370);
    test_output_backpressure();

    s_axis_tvalid_i <= 1'b0;
    while (awaited_sleep_types.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> aml_s5_sleep_type_scanner.f
rtl/aml_s5_pkg.sv
rtl/aml_s5_win.sv
rtl/aml_s5_match.sv
rtl/aml_s5_sleep_type_scanner.sv
tb/tb_aml_s5_sleep_type_scanner.sv
